// ===== design/pva_pkg.sv =====
// pva_pkg: shared constants, field types and codes for the voice allocator.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps

package pva_pkg;

  localparam int PVA_NUM_VOICES_DEF = 8;   // default voice count
  localparam int PVA_MAX_RESULTS    = 8;   // results reported per release beat
  localparam int PVA_RCNT_W         = 4;   // holds 0..PVA_MAX_RESULTS

  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int VIDX_W = 3;

  typedef logic [NOTE_W-1:0] note_t;
  typedef logic [VEL_W-1:0]  vel_t;
  typedef logic [VIDX_W-1:0] vidx_t;

  // input opcodes
  localparam logic OP_PRESS   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result kinds
  localparam logic EV_START   = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

endpackage

// ===== design/pva_if.sv =====
// pva_if: valid/ready channel interfaces for note events and voice results.
// Depends on pva_pkg.
`timescale 1ns / 1ps

interface pva_in_if
  import pva_pkg::*;
  ;
  logic  valid;
  logic  ready;
  logic  opcode;
  note_t note_number;
  vel_t  strike_velocity;

  modport source (output valid, output opcode, output note_number,
                  output strike_velocity, input ready);
  modport sink   (input valid, input opcode, input note_number,
                  input strike_velocity, output ready);
endinterface

interface pva_out_if
  import pva_pkg::*;
  ;
  logic  valid;
  logic  ready;
  vidx_t voice_index;
  logic  event_kind;
  note_t voice_note;
  vel_t  voice_velocity;
  logic  was_stolen;
  logic  last_of_run;

  modport source (output valid, output voice_index, output event_kind,
                  output voice_note, output voice_velocity, output was_stolen,
                  output last_of_run, input ready);
  modport sink   (input valid, input voice_index, input event_kind,
                  input voice_note, input voice_velocity, input was_stolen,
                  input last_of_run, output ready);
endinterface

// ===== design/poly_voice_allocator.sv =====
// poly_voice_allocator: note press/release to synth voice assignment with
// oldest-note stealing. Depends on pva_pkg and pva_if.
`timescale 1ns / 1ps

// Usage
//   in_ch  : note event beats (opcode, note_number, strike_velocity).
//   out_ch : voice result beats (voice_index, event_kind, voice_note,
//            voice_velocity, was_stolen, last_of_run). last_of_run marks the
//            final result of one event; a release matching no voice gives none.
//   One event is worked on at a time; in_ch.ready is high only while idle.
//   Steps per event, N = NUM_VOICES, set by the single-port voice memory
//   (each entry is read, then worked on):
//     press, free voice available : free ring read, then voice entry written
//     press, all voices busy      : age sweep over the voice memory
//     release, some voice matches : match sweep, then age renumber
//     release, no voice matches   : match sweep only, no result
//   Each voice entry holds its note and its age rank in the press order.
//   The free voice queue is a ring in a second memory.
//   Results leave through an output register; while it is stalled the match
//   sweep waits on the next match and the final result waits, so nothing drops.
//   Reset (synchronous, active low) marks all voices idle and makes the free
//   ring read as voices 0..N-1 through per-slot written bits; no clearing
//   pass, the block takes events in the first cycle after reset.
module poly_voice_allocator
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = PVA_NUM_VOICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pva_in_if.sink      in_ch,
  pva_out_if.source   out_ch
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;  // voice index
  localparam int CW = $clog2(NUM_VOICES + 1);                     // voice count
  localparam int SW = CW + 1;                                     // ring sum
  localparam int HW = NOTE_W + VW;                                // {note, rank}

  localparam logic [VW-1:0] LAST_VOICE = VW'(NUM_VOICES - 1);
  localparam logic [CW-1:0] ALL_VOICES = CW'(NUM_VOICES);
  localparam logic [PVA_RCNT_W-1:0] RES_LIMIT = PVA_RCNT_W'(PVA_MAX_RESULTS);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PR_DO = 4'd1;  // free voice read back
  localparam logic [3:0] ST_ST_RD = 4'd2;  // steal sweep: read entry
  localparam logic [3:0] ST_ST_DO = 4'd3;  // steal sweep: age entry
  localparam logic [3:0] ST_RL_RD = 4'd4;  // release sweep: read entry
  localparam logic [3:0] ST_RL_DO = 4'd5;  // release sweep: match entry
  localparam logic [3:0] ST_RN_RD = 4'd6;  // renumber sweep: read entry
  localparam logic [3:0] ST_RN_DO = 4'd7;  // renumber sweep: close rank gaps
  localparam logic [3:0] ST_FIN   = 4'd8;  // send the held-back last result

  logic [3:0] state_r, state_nxt;

  // latched event
  note_t note_r, note_nxt;
  vel_t  vel_r, vel_nxt;

  // sweep position
  logic [VW-1:0] idx_r, idx_nxt;

  // voice memory: {note, age rank}, meaningful only where held_r is set
  logic [HW-1:0]         held_mem_r [NUM_VOICES];
  logic [HW-1:0]         hm_rdata_r;
  logic                  hm_re;
  logic                  hm_we;
  logic [VW-1:0]         hm_waddr;
  logic [HW-1:0]         hm_wdata;
  logic [NUM_VOICES-1:0] held_r, held_nxt;

  // free ring
  logic [VW-1:0]         fq_mem_r [NUM_VOICES];
  logic [VW-1:0]         fq_rdata_r;
  logic [VW-1:0]         fq_raddr_r;
  logic                  fq_rwr_r;
  logic                  fq_re;
  logic                  fq_we;
  logic [VW-1:0]         fq_waddr;
  logic [NUM_VOICES-1:0] fq_wr_r, fq_wr_nxt;
  logic [VW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         free_cnt_r, free_cnt_nxt;

  // release bookkeeping
  logic [NUM_VOICES-1:0] rem_mask_r, rem_mask_nxt;   // ranks freed this event
  logic [PVA_RCNT_W-1:0] rep_cnt_r, rep_cnt_nxt;

  // held-back result (sent once the next one, or the end, is known)
  logic          pend_vld_r, pend_vld_nxt;
  logic [VW-1:0] pend_voice_r, pend_voice_nxt;
  logic          pend_kind_r, pend_kind_nxt;
  logic          pend_stolen_r, pend_stolen_nxt;

  // output register
  logic  out_vld_r, out_vld_nxt;
  vidx_t out_voice_r, out_voice_nxt;
  logic  out_kind_r, out_kind_nxt;
  note_t out_note_r, out_note_nxt;
  vel_t  out_vel_r, out_vel_nxt;
  logic  out_stolen_r, out_stolen_nxt;
  logic  out_last_r, out_last_nxt;

  logic          out_free;
  logic [VW-1:0] fq_voice;
  logic [VW-1:0] cur_rank;
  note_t         cur_note;
  logic [SW-1:0] tail_sum;
  logic [VW-1:0] tail;
  logic [CW-1:0] gap_cnt;
  logic          in_acc;

  assign out_free = !out_vld_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign fq_voice = fq_rwr_r ? fq_rdata_r : fq_raddr_r;
  assign cur_rank = hm_rdata_r[VW-1:0];
  assign cur_note = hm_rdata_r[HW-1:VW];

  // ring tail = head + count, wrapped once
  always_comb begin
    tail_sum = SW'(head_r) + SW'(free_cnt_r);
    if (tail_sum >= SW'(NUM_VOICES)) begin
      tail_sum = tail_sum - SW'(NUM_VOICES);
    end
    tail = tail_sum[VW-1:0];
  end

  // freed ranks below this entry's rank
  always_comb begin
    gap_cnt = '0;
    for (int k = 0; k < NUM_VOICES; k++) begin
      if (rem_mask_r[k] && (k < int'(cur_rank))) begin
        gap_cnt = gap_cnt + CW'(1);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    note_nxt        = note_r;
    vel_nxt         = vel_r;
    idx_nxt         = idx_r;
    held_nxt        = held_r;
    fq_wr_nxt       = fq_wr_r;
    head_nxt        = head_r;
    free_cnt_nxt    = free_cnt_r;
    rem_mask_nxt    = rem_mask_r;
    rep_cnt_nxt     = rep_cnt_r;
    pend_vld_nxt    = pend_vld_r;
    pend_voice_nxt  = pend_voice_r;
    pend_kind_nxt   = pend_kind_r;
    pend_stolen_nxt = pend_stolen_r;
    out_vld_nxt     = out_vld_r && !out_ch.ready;
    out_voice_nxt   = out_voice_r;
    out_kind_nxt    = out_kind_r;
    out_note_nxt    = out_note_r;
    out_vel_nxt     = out_vel_r;
    out_stolen_nxt  = out_stolen_r;
    out_last_nxt    = out_last_r;
    hm_re           = 1'b0;
    hm_we           = 1'b0;
    hm_waddr        = idx_r;
    hm_wdata        = hm_rdata_r;
    fq_re           = 1'b0;
    fq_we           = 1'b0;
    fq_waddr        = tail;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          note_nxt     = in_ch.note_number;
          vel_nxt      = in_ch.strike_velocity;
          idx_nxt      = '0;
          rem_mask_nxt = '0;
          rep_cnt_nxt  = '0;
          pend_vld_nxt = 1'b0;
          if (in_ch.opcode == OP_RELEASE) begin
            state_nxt = ST_RL_RD;
          end else if (free_cnt_r != '0) begin
            fq_re     = 1'b1;
            state_nxt = ST_PR_DO;
          end else begin
            state_nxt = ST_ST_RD;
          end
        end
      end

      ST_PR_DO: begin
        // oldest free voice becomes the newest pressed one
        hm_we           = 1'b1;
        hm_waddr        = fq_voice;
        hm_wdata        = {note_r, VW'(ALL_VOICES - free_cnt_r)};
        held_nxt[fq_voice] = 1'b1;
        head_nxt        = (head_r == LAST_VOICE) ? '0 : head_r + VW'(1);
        free_cnt_nxt    = free_cnt_r - CW'(1);
        pend_vld_nxt    = 1'b1;
        pend_voice_nxt  = fq_voice;
        pend_kind_nxt   = EV_START;
        pend_stolen_nxt = 1'b0;
        state_nxt       = ST_FIN;
      end

      ST_ST_RD: begin
        hm_re     = 1'b1;
        state_nxt = ST_ST_DO;
      end

      ST_ST_DO: begin
        // all voices are held; rank 0 is stolen and becomes the newest
        hm_we = 1'b1;
        if (cur_rank == '0) begin
          hm_wdata        = {note_r, LAST_VOICE};
          pend_vld_nxt    = 1'b1;
          pend_voice_nxt  = idx_r;
          pend_kind_nxt   = EV_START;
          pend_stolen_nxt = 1'b1;
        end else begin
          hm_wdata = {cur_note, cur_rank - VW'(1)};
        end
        if (idx_r == LAST_VOICE) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + VW'(1);
          state_nxt = ST_ST_RD;
        end
      end

      ST_RL_RD: begin
        hm_re     = 1'b1;
        state_nxt = ST_RL_DO;
      end

      ST_RL_DO: begin
        if (held_r[idx_r] && (cur_note == note_r) &&
            (rep_cnt_r < RES_LIMIT) && pend_vld_r && !out_free) begin
          // previous match still waiting for the output register
          state_nxt = ST_RL_DO;
        end else begin
          if (held_r[idx_r] && (cur_note == note_r)) begin
            held_nxt[idx_r]        = 1'b0;
            fq_we                  = 1'b1;
            fq_wr_nxt[tail]        = 1'b1;
            free_cnt_nxt           = free_cnt_r + CW'(1);
            rem_mask_nxt[cur_rank] = 1'b1;
            if (rep_cnt_r < RES_LIMIT) begin
              if (pend_vld_r) begin
                out_vld_nxt    = 1'b1;
                out_voice_nxt  = VIDX_W'(pend_voice_r);
                out_kind_nxt   = EV_RELEASE;
                out_note_nxt   = note_r;
                out_vel_nxt    = '0;
                out_stolen_nxt = 1'b0;
                out_last_nxt   = 1'b0;
              end
              pend_vld_nxt    = 1'b1;
              pend_voice_nxt  = idx_r;
              pend_kind_nxt   = EV_RELEASE;
              pend_stolen_nxt = 1'b0;
              rep_cnt_nxt     = rep_cnt_r + PVA_RCNT_W'(1);
            end
          end
          if (idx_r == LAST_VOICE) begin
            idx_nxt   = '0;
            state_nxt = pend_vld_nxt ? ST_RN_RD : ST_IDLE;
          end else begin
            idx_nxt   = idx_r + VW'(1);
            state_nxt = ST_RL_RD;
          end
        end
      end

      ST_RN_RD: begin
        hm_re     = 1'b1;
        state_nxt = ST_RN_DO;
      end

      ST_RN_DO: begin
        // close the rank gaps left by the released voices
        if (held_r[idx_r]) begin
          hm_we    = 1'b1;
          hm_wdata = {cur_note, cur_rank - VW'(gap_cnt)};
        end
        if (idx_r == LAST_VOICE) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + VW'(1);
          state_nxt = ST_RN_RD;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_voice_nxt  = VIDX_W'(pend_voice_r);
          out_kind_nxt   = pend_kind_r;
          out_note_nxt   = note_r;
          out_vel_nxt    = (pend_kind_r == EV_RELEASE) ? '0 : vel_r;
          out_stolen_nxt = pend_stolen_r;
          out_last_nxt   = 1'b1;
          pend_vld_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (hm_we) begin
      held_mem_r[hm_waddr] <= hm_wdata;
    end
    if (hm_re) begin
      hm_rdata_r <= held_mem_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (fq_we) begin
      fq_mem_r[fq_waddr] <= idx_r;
    end
    if (fq_re) begin
      fq_rdata_r <= fq_mem_r[head_r];
      fq_raddr_r <= head_r;
      fq_rwr_r   <= fq_wr_r[head_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      held_r     <= '0;
      fq_wr_r    <= '0;
      head_r     <= '0;
      free_cnt_r <= ALL_VOICES;
      rep_cnt_r  <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_r     <= held_nxt;
      fq_wr_r    <= fq_wr_nxt;
      head_r     <= head_nxt;
      free_cnt_r <= free_cnt_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    note_r        <= note_nxt;
    vel_r         <= vel_nxt;
    idx_r         <= idx_nxt;
    rem_mask_r    <= rem_mask_nxt;
    pend_voice_r  <= pend_voice_nxt;
    pend_kind_r   <= pend_kind_nxt;
    pend_stolen_r <= pend_stolen_nxt;
    out_voice_r   <= out_voice_nxt;
    out_kind_r    <= out_kind_nxt;
    out_note_r    <= out_note_nxt;
    out_vel_r     <= out_vel_nxt;
    out_stolen_r  <= out_stolen_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.voice_index    = out_voice_r;
  assign out_ch.event_kind     = out_kind_r;
  assign out_ch.voice_note     = out_note_r;
  assign out_ch.voice_velocity = out_vel_r;
  assign out_ch.was_stolen     = out_stolen_r;
  assign out_ch.last_of_run    = out_last_r;

endmodule

// ===== design/pva_checker.sv =====
// pva_checker: port-level assertions for poly_voice_allocator, bound to it.
// Depends on pva_pkg.
`timescale 1ns / 1ps

module pva_checker
  import pva_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input vidx_t out_voice_index,
  input logic  out_event_kind,
  input vel_t  out_voice_velocity,
  input logic  out_was_stolen,
  input logic  out_last_of_run
);

  // one event at a time: ready drops right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an event was in flight");

  // a press gives exactly one result, so it closes its run
  a_start_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_START) |-> out_last_of_run)
    else $error("start result without last_of_run");

  // release results carry no velocity and are never stolen
  a_release_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_RELEASE) |->
      (out_voice_velocity == '0) && !out_was_stolen)
    else $error("release result with velocity or stolen flag");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_voice_index) && $stable(out_event_kind) &&
      $stable(out_last_of_run))
    else $error("result beat changed under stall");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_voice_index    (out_ch.voice_index),
  .out_event_kind     (out_ch.event_kind),
  .out_voice_velocity (out_ch.voice_velocity),
  .out_was_stolen     (out_ch.was_stolen),
  .out_last_of_run    (out_ch.last_of_run)
);
